// ----- rtl/core/tlvrf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvrf_pkg
// Shared types and constants for the type-length-value record finder.
// ----------------------------------------------------------------------------
package tlvrf_pkg;

   // largest buffer the parser accepts, and the position counter ceiling
   localparam logic [12:0] BUFFER_BYTES = 13'd4096;
   localparam logic [12:0] POS_MAX      = 13'd8191;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_TYPE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH = 1'd1;

   // result codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // one buffer byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // one search result
   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] data_offset;
      logic [12:0] data_size;
   } rsp_type;

   // head of the byte queue as seen by the parser
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   // configuration as seen by the parser
   typedef struct packed {
      logic signed [31:0] target_type;
      logic [12:0]        eff_length;
   } cfg_type;

   // parser phase
   typedef enum logic [1:0] {
      PH_COUNT,
      PH_TYPE,
      PH_SIZE,
      PH_SKIP
   } phase_type;

endpackage

// ----- rtl/core/tlvrf_front.sv -----
// ----------------------------------------------------------------------------
// tlvrf_front
// Input side: takes buffer bytes into a short queue that feeds the parser.
// ----------------------------------------------------------------------------
module tlvrf_front import tlvrf_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           head_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   req_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   // transfer qualifiers
   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = head.valid && head_pop;

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ----- rtl/core/tlvrf_parser.sv -----
// ----------------------------------------------------------------------------
// tlvrf_parser
// Back end: walks the record stream one byte per cycle while the result slot
// is free or not stalled, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tlvrf_parser import tlvrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_head_type head,
   output logic           head_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   phase_type    phase_ff, phase_in;
   logic         decided_ff, decided_in;
   logic [12:0]  pos_ff, pos_in;
   logic [31:0]  asm_ff, asm_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [31:0]  rl_ff, rl_in;
   logic [31:0]  type_ff, type_in;
   logic [12:0]  skip_ff, skip_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   logic         take;
   logic         step;
   logic [7:0]   in_byte;
   logic [31:0]  byte_shift;
   logic [31:0]  asm_full;
   logic         field_done;
   logic         count_short;
   logic [13:0]  pos1;
   logic [14:0]  hdr_end;
   logic         hdr_past;
   logic [14:0]  data_end;
   logic         size_bad;
   logic         type_match;
   logic [31:0]  rl_minus;
   logic [31:0]  rec_rl;
   logic         rec_none;
   logic [12:0]  skip_dec;
   logic         res_fire;
   rsp_type      res;

   // a byte moves out of the queue when the result slot can take a result
   assign take     = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign head_pop = take;
   assign step     = take && !decided_ff;
   assign in_byte  = head.item.data_byte;

   // little-endian field assembly
   always_comb begin
      case (cnt_ff)
         2'd0:    byte_shift = {24'd0, in_byte};
         2'd1:    byte_shift = {16'd0, in_byte, 8'd0};
         2'd2:    byte_shift = {8'd0, in_byte, 16'd0};
         default: byte_shift = {in_byte, 24'd0};
      endcase
   end

   assign asm_full   = asm_ff | byte_shift;
   assign field_done = (cnt_ff == 2'd3);
   assign count_short = (cnt_ff == 2'd0) && (cfg.eff_length < 13'd4);

   // offset checks
   assign pos1     = {1'b0, pos_ff} + 14'd1;
   assign hdr_end  = {1'b0, pos1} + 15'd8;
   assign hdr_past = hdr_end > {2'b00, cfg.eff_length};
   assign data_end = {1'b0, pos1} + {2'b00, asm_full[12:0]};
   assign size_bad = asm_full[31] || (asm_full > {19'd0, cfg.eff_length})
                     || (data_end > {2'b00, cfg.eff_length});
   assign type_match = (type_ff == cfg.target_type);
   assign rl_minus   = rl_ff - 32'd1;
   assign skip_dec   = (skip_ff != 13'd0) ? skip_ff - 13'd1 : 13'd0;

   // record count seen when the next record header is due
   always_comb begin
      case (phase_ff)
         PH_COUNT: rec_rl = asm_full;
         PH_SIZE:  rec_rl = rl_minus;
         default:  rec_rl = rl_ff;
      endcase
   end

   assign rec_none = (rec_rl == 32'd0);

   // next phase and decision
   always_comb begin
      phase_in   = phase_ff;
      decided_in = decided_ff;
      res_fire   = 1'b0;
      res        = '{status: ST_MALFORMED, data_offset: 13'd0, data_size: 13'd0};
      if (step) begin
         case (phase_ff)
            PH_COUNT: begin
               if (count_short) begin
                  res_fire = 1'b1;
               end else if (field_done) begin
                  if (asm_full == 32'd0 || asm_full[31]) begin
                     res_fire   = 1'b1;
                     res.status = ST_NOTFOUND;
                  end else if (hdr_past) begin
                     res_fire = 1'b1;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_TYPE: begin
               if (field_done) begin
                  phase_in = PH_SIZE;
               end
            end
            PH_SIZE: begin
               if (field_done) begin
                  if (size_bad) begin
                     res_fire = 1'b1;
                  end else if (type_match) begin
                     res_fire        = 1'b1;
                     res.status      = ST_FOUND;
                     res.data_offset = pos1[12:0];
                     res.data_size   = asm_full[12:0];
                  end else if (asm_full != 32'd0) begin
                     phase_in = PH_SKIP;
                  end else if (rec_none) begin
                     res_fire   = 1'b1;
                     res.status = ST_NOTFOUND;
                  end else if (hdr_past) begin
                     res_fire = 1'b1;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_SKIP: begin
               if (skip_dec == 13'd0) begin
                  if (rec_none) begin
                     res_fire   = 1'b1;
                     res.status = ST_NOTFOUND;
                  end else if (hdr_past) begin
                     res_fire = 1'b1;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase
      end
      if (res_fire) begin
         decided_in = 1'b1;
      end
      // last byte: early end is malformed, then the parser starts over
      if (take && head.item.last_byte) begin
         if (!decided_ff && !res_fire) begin
            res_fire = 1'b1;
            res      = '{status: ST_MALFORMED, data_offset: 13'd0, data_size: 13'd0};
         end
         phase_in   = PH_COUNT;
         decided_in = 1'b0;
      end
   end

   // field and counter updates
   always_comb begin
      pos_in  = pos_ff;
      asm_in  = asm_ff;
      cnt_in  = cnt_ff;
      rl_in   = rl_ff;
      type_in = type_ff;
      skip_in = skip_ff;
      if (take && pos_ff != POS_MAX) begin
         pos_in = pos_ff + 13'd1;
      end
      if (step) begin
         case (phase_ff)
            PH_COUNT, PH_TYPE, PH_SIZE: begin
               if (!(phase_ff == PH_COUNT && count_short)) begin
                  if (field_done) begin
                     asm_in = 32'd0;
                     cnt_in = 2'd0;
                     case (phase_ff)
                        PH_COUNT: rl_in = asm_full;
                        PH_TYPE:  type_in = asm_full;
                        default: begin
                           rl_in   = rl_minus;
                           skip_in = asm_full[12:0];
                        end
                     endcase
                  end else begin
                     asm_in = asm_full;
                     cnt_in = cnt_ff + 2'd1;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
            end
            default: begin
               skip_in = skip_ff;
            end
         endcase
      end
      if (take && head.item.last_byte) begin
         pos_in  = 13'd0;
         asm_in  = 32'd0;
         cnt_in  = 2'd0;
         rl_in   = 32'd0;
         type_in = 32'd0;
         skip_in = 13'd0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COUNT;
         decided_ff <= 1'b0;
         pos_ff     <= 13'd0;
         asm_ff     <= 32'd0;
         cnt_ff     <= 2'd0;
         rl_ff      <= 32'd0;
         type_ff    <= 32'd0;
         skip_ff    <= 13'd0;
      end else begin
         phase_ff   <= phase_in;
         decided_ff <= decided_in;
         pos_ff     <= pos_in;
         asm_ff     <= asm_in;
         cnt_ff     <= cnt_in;
         rl_ff      <= rl_in;
         type_ff    <= type_in;
         skip_ff    <= skip_in;
      end
   end

   // result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/tlv_record_finder.sv -----
// ----------------------------------------------------------------------------
// tlv_record_finder
// Searches a streamed type-length-value buffer for the first record of the
// configured type and reports found, not found or malformed per buffer.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the transfer of the byte that
//   settles it; the byte may first wait in the input queue
// throughput: one byte per cycle unless rsp_stall holds a pending result, set by the single-byte parser step
// reset: synchronous; empties the queue and result slot, restarts the
//   parser, target_type returns to 0 and buffer_length to 4096
module tlv_record_finder import tlvrf_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   logic signed [31:0] target_type_ff;
   logic [12:0]        buffer_length_ff;
   cfg_type            cfg;
   queue_head_type     head;
   logic               head_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff   <= 32'sd0;
         buffer_length_ff <= BUFFER_BYTES;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_TYPE:   target_type_ff   <= csr_wdata;
            CSR_BUFFER_LENGTH: buffer_length_ff <= csr_wdata[12:0];
            default:           target_type_ff   <= target_type_ff;
         endcase
      end
   end

   // effective length is capped at the buffer size
   assign cfg.target_type = target_type_ff;
   assign cfg.eff_length  = (buffer_length_ff < BUFFER_BYTES) ? buffer_length_ff
                                                              : BUFFER_BYTES;

   tlvrf_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .head_pop  (head_pop)
   );

   tlvrf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
